>>> design/fnb_pkg.sv
package fnb_pkg;

   localparam int CH_W    = 8;
   localparam int NUM_CH  = 3;
   localparam int POS_W   = 6;
   localparam int DIM_W   = 7;
   localparam int CSR_A_W = 2;
   localparam int NUM_NB  = 4;
   localparam int NUM_LANES = 3;

   // floor(x/3) == (x*683)>>11 for every x up to 4*255
   localparam int DIV3_MUL   = 683;
   localparam int DIV3_SHIFT = 11;

   localparam logic [CSR_A_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_BLUR_ENABLE  = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

   // channel 0 is red, in the low bits
   typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_type;

   typedef struct packed {
      logic              eof;
      logic              last;
      logic [POS_W-1:0]  col;
      logic [POS_W-1:0]  row;
      pixel_type         pix;
   } result_type;

endpackage

>>> design/fnb_lane.sv
module fnb_lane (
   input  fnb_pkg::pixel_type [fnb_pkg::NUM_NB-1:0] nb_i,
   input  logic [fnb_pkg::NUM_NB-1:0]               nb_valid_i,
   output fnb_pkg::pixel_type                       avg_o
);
   import fnb_pkg::*;

   localparam int SUM_W = CH_W + 2;
   localparam int PROD_W = SUM_W + 10;

   logic [2:0]         count;
   logic [SUM_W-1:0]   sum   [NUM_CH];
   logic [PROD_W-1:0]  prod  [NUM_CH];

   always_comb begin
      count = '0;
      for (int i = 0; i < NUM_NB; i++) begin
         count = count + 3'(nb_valid_i[i]);
      end
      for (int ch = 0; ch < NUM_CH; ch++) begin
         sum[ch] = '0;
         for (int i = 0; i < NUM_NB; i++) begin
            if (nb_valid_i[i]) begin
               sum[ch] = sum[ch] + SUM_W'(nb_i[i][ch]);
            end
         end
         prod[ch] = PROD_W'(sum[ch]) * PROD_W'(DIV3_MUL);
         case (count)
            3'd4:    avg_o[ch] = CH_W'(sum[ch] >> 2);
            3'd3:    avg_o[ch] = CH_W'(prod[ch] >> DIV3_SHIFT);
            3'd2:    avg_o[ch] = CH_W'(sum[ch] >> 1);
            default: avg_o[ch] = '0;
         endcase
      end
   end

endmodule

>>> design/fnb_merge.sv
module fnb_merge (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        load_valid_i,
   input  fnb_pkg::result_type [fnb_pkg::NUM_LANES-1:0] slot_i,
   input  logic [fnb_pkg::NUM_LANES-1:0]               mask_i,
   output logic                                        load_ready_o,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // red[7:0], green[15:8], blue[23:16], pixel_row[29:24], pixel_column[35:30], zero
   output logic [39:0]                                 rsp_tdata,
   output logic                                        rsp_tlast,
   // end_of_frame
   output logic                                        rsp_tuser
);
   import fnb_pkg::*;

   result_type [NUM_LANES-1:0] slot_ff;
   logic [NUM_LANES-1:0]       mask_ff, mask_in;
   logic [NUM_LANES-1:0]       mask_rest;
   result_type                 cur;
   logic                       take;

   always_comb begin
      // lowest pending slot goes out first
      if (mask_ff[0]) begin
         cur = slot_ff[0];
      end else if (mask_ff[1]) begin
         cur = slot_ff[1];
      end else begin
         cur = slot_ff[2];
      end
      rsp_tvalid = |mask_ff;
      take       = rsp_tvalid & rsp_tready;
      mask_rest  = mask_ff & (mask_ff - NUM_LANES'(1));
      load_ready_o = ~rsp_tvalid | (take & (mask_rest == '0));
      mask_in = mask_ff;
      if (load_ready_o & load_valid_i) begin
         mask_in = mask_i;
      end else if (take) begin
         mask_in = mask_rest;
      end
      rsp_tdata = {4'b0, cur.col, cur.row, cur.pix};
      rsp_tlast = cur.last;
      rsp_tuser = cur.eof;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ready_o & load_valid_i) begin
         slot_ff <= slot_i;
      end
   end

endmodule

>>> design/four_neighbour_blur_pass_unit.sv
// Four-neighbor average blur, one pass over an RGB frame streamed in raster order.
// req_*: one pixel word per handshake, red/green/blue in tdata.
// rsp_*: result words carrying the blurred pixel and its row/column; tlast marks
//   the final word caused by one input pixel, tuser marks the bottom-right pixel.
// csr_*: frame_width (0), frame_height (1), blur_enable (2); write only when idle.
//   A width or height write restarts the frame at row 0, column 0.
// With blur on, the result for pixel (r-1,c) leaves when pixel (r,c) arrives; on
// the last row the row's own results follow one column behind, hence the position
// fields. Two register stages, stage 1 and the output slot register in fnb_merge,
// lie between a pixel and its words. Throughput: one pixel per cycle while
// rsp_tready is high; on the last row every pixel after the first makes two words
// and the last pixel three, so the single output port holds the input back there.
// Three averaging lanes run in parallel per pixel; the line store holds two rows of
// 2**CW words (CW = $clog2(MAX_WIDTH)), one write and two reads per accepted pixel.
// Reset zeroes the position counters and loads width 64, height 64, blur on;
// the line store is not cleared. A stalled rsp_tready holds the output word and
// backs up into req_tready after one held pixel.
module four_neighbour_blur_pass_unit #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // red[7:0], green[15:8], blue[23:16]
   input  logic [23:0]                  req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // red[7:0], green[15:8], blue[23:16], pixel_row[29:24], pixel_column[35:30], zero
   output logic [39:0]                  rsp_tdata,
   output logic                         rsp_tlast,
   // end_of_frame
   output logic                         rsp_tuser,
   input  logic                         csr_we,
   input  logic [fnb_pkg::CSR_A_W-1:0]  csr_index,
   input  logic [fnb_pkg::DIM_W-1:0]    csr_wdata
);
   import fnb_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   // configuration
   logic [DIM_W-1:0] fw_ff, fw_in, fh_ff, fh_in;
   logic             blur_ff, blur_in;
   logic [WW-1:0]    w_eff;
   logic [HW-1:0]    h_eff;

   // input position
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          last_col_now, last_row_now;
   logic          accept;
   logic          geom_write;

   // line store
   pixel_type     line_mem [2**(CW+1)];
   logic [CW:0]   wr_addr, prev_addr;

   // stage 1
   logic          s1_valid_ff, s1_valid_in;
   pixel_type     s1_pix_ff;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic          s1_last_col_ff, s1_last_row_ff;
   pixel_type     rd_next_ff, rd_up2_ff;
   logic          s1_take;

   // sliding windows: prev row at c and c-1, current row at c-1 and c-2
   pixel_type     pc_ff, pl_ff, q1_ff, q2_ff, first_cur_ff;

   logic          load_ready;
   logic          r_ge1, r_ge2, c_ge1, c_ge2;

   pixel_type [NUM_NB-1:0]     lane_nb    [NUM_LANES];
   logic [NUM_NB-1:0]          lane_nv    [NUM_LANES];
   pixel_type                  lane_avg   [NUM_LANES];
   result_type [NUM_LANES-1:0] slot;
   logic [NUM_LANES-1:0]       mask;

   // ---------------- configuration and counters ----------------
   always_comb begin
      if (fw_ff < DIM_W'(2)) begin
         w_eff = WW'(2);
      end else if (32'(fw_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(fw_ff);
      end
      if (fh_ff < DIM_W'(2)) begin
         h_eff = HW'(2);
      end else if (32'(fh_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(fh_ff);
      end

      fw_in   = fw_ff;
      fh_in   = fh_ff;
      blur_in = blur_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  fw_in   = csr_wdata;
            CSR_FRAME_HEIGHT: fh_in   = csr_wdata;
            CSR_BLUR_ENABLE:  blur_in = csr_wdata[0];
            default:          ;
         endcase
      end
      geom_write = csr_we &
                   ((csr_index == CSR_FRAME_WIDTH) | (csr_index == CSR_FRAME_HEIGHT));

      req_tready  = ~s1_valid_ff | load_ready;
      accept      = req_tvalid & req_tready;
      s1_take     = s1_valid_ff & load_ready;
      s1_valid_in = accept | (s1_valid_ff & ~load_ready);

      last_col_now = (WW'(col_ff) + WW'(1)) >= w_eff;
      last_row_now = (HW'(row_ff) + HW'(1)) >= h_eff;

      col_in = col_ff;
      row_in = row_ff;
      if (geom_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col_now) begin
            col_in = '0;
            row_in = last_row_now ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end

      wr_addr   = {row_ff[0], col_ff};
      prev_addr = {~row_ff[0], col_ff + CW'(1)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff       <= DIM_RESET;
         fh_ff       <= DIM_RESET;
         blur_ff     <= 1'b1;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         fw_ff       <= fw_in;
         fh_ff       <= fh_in;
         blur_ff     <= blur_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // line store: reads see the word from before this cycle's write
   always_ff @(posedge clock) begin
      if (accept) begin
         line_mem[wr_addr] <= pixel_type'(req_tdata);
         rd_next_ff        <= line_mem[prev_addr];
         rd_up2_ff         <= line_mem[wr_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= pixel_type'(req_tdata);
         s1_col_ff      <= col_ff;
         s1_row_ff      <= row_ff;
         s1_last_col_ff <= last_col_now;
         s1_last_row_ff <= last_row_now;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         if (s1_col_ff == '0) begin
            pl_ff        <= first_cur_ff;
            first_cur_ff <= s1_pix_ff;
         end else begin
            pl_ff <= pc_ff;
         end
         pc_ff <= rd_next_ff;
         q2_ff <= q1_ff;
         q1_ff <= s1_pix_ff;
      end
   end

   // ---------------- lanes ----------------
   always_comb begin
      r_ge1 = 32'(s1_row_ff) >= 1;
      r_ge2 = 32'(s1_row_ff) >= 2;
      c_ge1 = 32'(s1_col_ff) >= 1;
      c_ge2 = 32'(s1_col_ff) >= 2;

      // pixel above: up, down, left, right
      lane_nb[0] = {rd_next_ff, pl_ff, s1_pix_ff, rd_up2_ff};
      lane_nv[0] = {~s1_last_col_ff, c_ge1, 1'b1, r_ge2};
      // left pixel on the last row: up, left, right
      lane_nb[1] = {s1_pix_ff, q2_ff, pl_ff, s1_pix_ff};
      lane_nv[1] = {1'b1, c_ge2, 1'b1, 1'b0};
      // bottom-right pixel: up, left
      lane_nb[2] = {q1_ff, pc_ff, s1_pix_ff, s1_pix_ff};
      lane_nv[2] = {1'b1, 1'b1, 1'b0, 1'b0};
   end

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      fnb_lane u_lane (
         .nb_i       (lane_nb[g]),
         .nb_valid_i (lane_nv[g]),
         .avg_o      (lane_avg[g])
      );
   end

   always_comb begin
      mask[0] = ~blur_ff | r_ge1;
      mask[1] = blur_ff & s1_last_row_ff & c_ge1;
      mask[2] = blur_ff & s1_last_row_ff & s1_last_col_ff;

      slot[0].pix  = blur_ff ? lane_avg[0] : s1_pix_ff;
      slot[0].row  = blur_ff ? POS_W'(s1_row_ff - RW'(1)) : POS_W'(s1_row_ff);
      slot[0].col  = POS_W'(s1_col_ff);
      slot[0].last = blur_ff ? ~(mask[1] | mask[2]) : 1'b1;
      slot[0].eof  = ~blur_ff & s1_last_row_ff & s1_last_col_ff;

      slot[1].pix  = lane_avg[1];
      slot[1].row  = POS_W'(s1_row_ff);
      slot[1].col  = POS_W'(s1_col_ff - CW'(1));
      slot[1].last = ~mask[2];
      slot[1].eof  = 1'b0;

      slot[2].pix  = lane_avg[2];
      slot[2].row  = POS_W'(s1_row_ff);
      slot[2].col  = POS_W'(s1_col_ff);
      slot[2].last = 1'b1;
      slot[2].eof  = 1'b1;
   end

   fnb_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .load_valid_i (s1_valid_ff),
      .slot_i       (slot),
      .mask_i       (mask),
      .load_ready_o (load_ready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

>>> bench/four_neighbour_blur_pass_unit_test.sv
`timescale 1ns / 1ps

module four_neighbour_blur_pass_unit_test;
   import fnb_pkg::*;

   localparam int MAX_COLS    = 64;
   localparam int MAX_ROWS    = 64;
   localparam int CYCLE_LIMIT = 100000;
   localparam int DRAIN_GAP   = 6;
   localparam int HOLD_CYCLES = 80;
   localparam logic [CSR_A_W-1:0] CSR_UNUSED = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;
   logic                rsp_tlast;
   logic                rsp_tuser;
   logic                csr_we = 1'b0;
   logic [CSR_A_W-1:0]  csr_index = '0;
   logic [DIM_W-1:0]    csr_wdata = '0;

   four_neighbour_blur_pass_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // blur predictor state
   logic [DIM_W-1:0] width_setting  = DIM_RESET;
   logic [DIM_W-1:0] height_setting = DIM_RESET;
   bit               blur_on        = 1'b1;
   int               cur_row        = 0;
   int               cur_col        = 0;
   pixel_type        line_rows [2][MAX_COLS];

   result_type awaited_words [$];
   int         mismatch_count = 0;
   int         words_checked  = 0;
   int         pixels_sent    = 0;
   int         csr_writes     = 0;
   bit         calm           = 1'b0;
   bit         hold_request   = 1'b0;
   string      chan_name [NUM_CH] = '{"red", "green", "blue"};

   typedef enum bit {STEP_CSR, STEP_PIXEL} step_kind_type;
   typedef struct {
      step_kind_type     kind;
      logic [CSR_A_W-1:0] index;
      logic [23:0]       value;
      bit                known;
      logic [23:0]       result_pix;
   } stim_step_type;

   // pixels are blue:green:red from the top byte down
   localparam int DIRECTED_LEN = 29;
   stim_step_type directed_steps [DIRECTED_LEN] = '{
      // blur on and height 64 after reset: one word per pixel of row 1
      '{STEP_CSR,   CSR_FRAME_WIDTH,  24'd2,       1'b0, 24'h0},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'hFFFFFF,  1'b0, 24'h0},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'h000000,  1'b0, 24'h0},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'h000000,  1'b1, 24'h000000},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'hFFFFFF,  1'b1, 24'hFFFFFF},
      // height write restarts the frame mid-way: 2x2 corner-only frame
      '{STEP_CSR,   CSR_FRAME_HEIGHT, 24'd2,       1'b0, 24'h0},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'hFFFFFF,  1'b0, 24'h0},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'h000000,  1'b0, 24'h0},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'h000000,  1'b1, 24'h000000},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'hFFFFFF,  1'b0, 24'h0},
      // pass-through
      '{STEP_CSR,   CSR_BLUR_ENABLE,  24'd0,       1'b0, 24'h0},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'h123456,  1'b1, 24'h123456},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'h00FF00,  1'b1, 24'h00FF00},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'hFF00FF,  1'b1, 24'hFF00FF},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'h000000,  1'b1, 24'h000000},
      // unused index must not touch the enable
      '{STEP_CSR,   CSR_BLUR_ENABLE,  24'd1,       1'b0, 24'h0},
      '{STEP_CSR,   CSR_UNUSED,       24'h7E,      1'b0, 24'h0},
      '{STEP_CSR,   CSR_FRAME_WIDTH,  24'd3,       1'b0, 24'h0},
      '{STEP_CSR,   CSR_FRAME_HEIGHT, 24'd3,       1'b0, 24'h0},
      // all-max 3x3: the sums peak but every mean stays 255
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'hFFFFFF,  1'b1, 24'hFFFFFF},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'hFFFFFF,  1'b1, 24'hFFFFFF},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'hFFFFFF,  1'b1, 24'hFFFFFF},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'hFFFFFF,  1'b1, 24'hFFFFFF},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'hFFFFFF,  1'b1, 24'hFFFFFF},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'hFFFFFF,  1'b1, 24'hFFFFFF},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'hFFFFFF,  1'b1, 24'hFFFFFF},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'hFFFFFF,  1'b1, 24'hFFFFFF},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  24'hFFFFFF,  1'b1, 24'hFFFFFF},
      '{STEP_CSR,   CSR_BLUR_ENABLE,  24'd1,       1'b0, 24'h0}
   };

   function automatic int effective_dim(input logic [DIM_W-1:0] v, input int max_dim);
      if (v < 2) return 2;
      if (v > max_dim) return max_dim;
      return int'(v);
   endfunction

   function automatic pixel_type stored_or_current(input int rr, input int cc, input int r,
                                                   input int c, input pixel_type cur);
      if (rr == r && cc == c) return cur;
      return line_rows[rr % 2][cc];
   endfunction

   function automatic pixel_type neighbour_mean(input int br, input int bc, input int r,
                                                input int c, input pixel_type cur,
                                                input int w, input int h);
      pixel_type nb [4];
      pixel_type mean;
      int n;
      int sum;
      n = 0;
      if (br > 0) begin
         nb[n] = stored_or_current(br - 1, bc, r, c, cur);
         n++;
      end
      if (br + 1 < h) begin
         nb[n] = stored_or_current(br + 1, bc, r, c, cur);
         n++;
      end
      if (bc > 0) begin
         nb[n] = stored_or_current(br, bc - 1, r, c, cur);
         n++;
      end
      if (bc + 1 < w) begin
         nb[n] = stored_or_current(br, bc + 1, r, c, cur);
         n++;
      end
      for (int ch = 0; ch < NUM_CH; ch++) begin
         sum = 0;
         for (int i = 0; i < n; i++) sum += nb[i][ch];
         mean[ch] = CH_W'(sum / n);
      end
      return mean;
   endfunction

   task automatic push_blur_word(input pixel_type pix, input int r, input int c,
                                 input bit last, input bit eof, input bit known,
                                 input pixel_type known_pix);
      result_type word;
      word.pix  = known ? known_pix : pix;
      word.row  = POS_W'(r);
      word.col  = POS_W'(c);
      word.last = last;
      word.eof  = eof;
      awaited_words.push_back(word);
   endtask

   // called once per accepted pixel word
   task automatic blur_pixel_arrival(input pixel_type px, input bit known,
                                     input pixel_type known_pix);
      int  w, h, r, c;
      bit  last_row, last_col, above, left_done, corner;
      w = effective_dim(width_setting, MAX_COLS);
      h = effective_dim(height_setting, MAX_ROWS);
      r = cur_row;
      c = cur_col;
      last_row = (r + 1 == h);
      last_col = (c + 1 == w);
      if (r >= h || c >= w) begin
         r = 0;
         c = 0;
         last_row = 1'b0;
         last_col = 1'b0;
      end
      if (!blur_on) begin
         push_blur_word(px, r, c, 1'b1, last_row && last_col, known, known_pix);
      end else begin
         above     = (r >= 1);
         left_done = last_row && (c >= 1);
         corner    = last_row && last_col;
         if (above)
            push_blur_word(neighbour_mean(r - 1, c, r, c, px, w, h), r - 1, c,
                           !left_done && !corner, 1'b0, known, known_pix);
         if (left_done)
            push_blur_word(neighbour_mean(r, c - 1, r, c, px, w, h), r, c - 1,
                           !corner, 1'b0, known, known_pix);
         if (corner)
            push_blur_word(neighbour_mean(r, c, r, c, px, w, h), r, c,
                           1'b1, 1'b1, known, known_pix);
      end
      line_rows[r % 2][c] = px;
      if (c + 1 >= w) begin
         cur_col = 0;
         cur_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         cur_col = c + 1;
         cur_row = r;
      end
   endtask

   task automatic report_field(input string name, input int want, input int got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
   endtask

   task automatic check_result_word(input result_type got);
      result_type want;
      if (awaited_words.size() == 0) begin
         $display("%0t: unexpected result word, expected none, actual %h", $time, got);
         mismatch_count++;
      end else begin
         want = awaited_words.pop_front();
         words_checked++;
         for (int ch = 0; ch < NUM_CH; ch++)
            if (got.pix[ch] !== want.pix[ch]) report_field(chan_name[ch], want.pix[ch], got.pix[ch]);
         if (got.row !== want.row) report_field("pixel_row", want.row, got.row);
         if (got.col !== want.col) report_field("pixel_column", want.col, got.col);
         if (got.last !== want.last) report_field("last_of_item", want.last, got.last);
         if (got.eof !== want.eof) report_field("end_of_frame", want.eof, got.eof);
      end
   endtask

   // result side: sample at the falling edge, where nothing is in motion
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            check_result_word(result_type'({rsp_tuser, rsp_tlast, rsp_tdata[35:0]}));
         @(posedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 21);
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: timeout with %0d words pending", $time, awaited_words.size());
      $display("four_neighbour_blur_pass_unit verification failed");
      $finish;
   end

   task automatic wait_drained();
      while (awaited_words.size() != 0) @(posedge clock);
   endtask

   task automatic send_pixel(input pixel_type px, input bit known, input pixel_type known_pix);
      bit accepted;
      if (!calm && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      accepted = 1'b0;
      while (!accepted) begin
         @(negedge clock);
         accepted = req_tready;
         @(posedge clock);
      end
      pixels_sent++;
      blur_pixel_arrival(px, known, known_pix);
   endtask

   // a pixel-free item may still be in flight after the last word, so pad the drain
   task automatic apply_csr(input logic [CSR_A_W-1:0] index, input logic [DIM_W-1:0] value);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (DRAIN_GAP) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      csr_writes++;
      case (index)
         CSR_FRAME_WIDTH: begin
            width_setting = value;
            cur_row = 0;
            cur_col = 0;
         end
         CSR_FRAME_HEIGHT: begin
            height_setting = value;
            cur_row = 0;
            cur_col = 0;
         end
         CSR_BLUR_ENABLE: blur_on = value[0];
         default: ;
      endcase
   endtask

   function automatic pixel_type random_pixel();
      pixel_type px;
      int pick;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         pick = $urandom_range(9);
         if (pick < 2) px[ch] = '0;
         else if (pick < 4) px[ch] = '1;
         else px[ch] = CH_W'($urandom);
      end
      return px;
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      if ($urandom_range(99) < 15) return DIM_W'($urandom_range(1));
      return DIM_W'($urandom_range(2, 6));
   endfunction

   task automatic feed_pixels(input int count, input int hold_at, input int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) hold_request = 1'b1;
         if (i == pause_at) begin
            req_tvalid <= 1'b0;
            wait_drained();
            @(posedge clock);
         end
         send_pixel(random_pixel(), 1'b0, '0);
      end
   endtask

   initial begin
      int random_goal;
      int w, h, frame_pixels, left_in_frame, count;
      bit first_random;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR)
            apply_csr(directed_steps[i].index, directed_steps[i].value[DIM_W-1:0]);
         else
            send_pixel(directed_steps[i].value, directed_steps[i].known,
                       directed_steps[i].result_pix);
      end

      // oversized width clamps to 64, undersized height to 2; no idling here
      apply_csr(CSR_FRAME_WIDTH, 7'd127);
      apply_csr(CSR_FRAME_HEIGHT, 7'd1);
      calm = 1'b1;
      feed_pixels(66, -1, -1);
      calm = 1'b0;

      // tallest frame, narrowest width; receiver holds off, later the sender drains
      apply_csr(CSR_FRAME_WIDTH, 7'd0);
      apply_csr(CSR_FRAME_HEIGHT, 7'd64);
      feed_pixels(30, 6, 22);

      random_goal = pixels_sent + 36;
      first_random = 1'b1;
      while (pixels_sent < random_goal) begin
         if (first_random || $urandom_range(1)) apply_csr(CSR_FRAME_WIDTH, pick_dim());
         if (first_random || $urandom_range(1)) apply_csr(CSR_FRAME_HEIGHT, pick_dim());
         if ($urandom_range(1)) apply_csr(CSR_BLUR_ENABLE, DIM_W'($urandom_range(127)));
         first_random = 1'b0;
         w = effective_dim(width_setting, MAX_COLS);
         h = effective_dim(height_setting, MAX_ROWS);
         frame_pixels = w * h;
         left_in_frame = frame_pixels - (cur_row * w + cur_col);
         // mostly run to the frame end, sometimes cut a frame short
         if ($urandom_range(9) < 7)
            count = left_in_frame + ($urandom_range(1) ? frame_pixels : 0);
         else
            count = $urandom_range(1, frame_pixels);
         if (count > random_goal - pixels_sent) count = random_goal - pixels_sent;
         feed_pixels(count, -1, -1);
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      $display("Sent %0d pixels over %0d register writes, %0d result words compared;",
               pixels_sent, csr_writes, words_checked);
      $display("small and clamped frame sizes, blur on and off, a long output stall, a drain.");
      if (mismatch_count == 0) begin
         $display("four_neighbour_blur_pass_unit verification clean");
      end else begin
         $display("four_neighbour_blur_pass_unit verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/fnb_pkg.sv
design/fnb_lane.sv
design/fnb_merge.sv
design/four_neighbour_blur_pass_unit.sv
bench/four_neighbour_blur_pass_unit_test.sv
